### hdl/swm_pkg.sv
// Shared types and constants for the sliding window maximum unit.
// Used by swm_cell, swm_readout and sliding_window_maximum_unit.
// No dependencies.
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int LEN_W        = 7;
  localparam int LEN_RST      = 3;

  localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = IDX_W + 1;
  localparam int LANE_W  = (IDX_W + 1) / 2;
  localparam int LANES   = 1 << LANE_W;
  localparam int GRP_W   = (IDX_W - LANE_W > 0) ? (IDX_W - LANE_W) : 1;
  localparam int GROUPS  = (WINDOW_MAX + LANES - 1) / LANES;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic              vld;
    logic [GRP_W-1:0]  grp;
    logic [LANE_W-1:0] lane;
  } sel_ctl_t;

endpackage

`default_nettype wire

### hdl/sliding_window_maximum_unit.sv
// Sliding window maximum: cell k of a row of cells keeps the maximum of the last k+1 samples.
// Each result passes through the two registered readout levels, the lane select (gp_r) and the
// group select output (out_r), before out_valid rises; an output stall can hold it in them.
// Throughput: one sample per cycle; the input stalls only while both levels hold a result.
// Synchronous active-low reset clears the fill count and the pipeline valids and sets the window
// length to 3; cell contents are not cleared. Depends on swm_pkg, swm_cell and swm_readout.
`default_nettype none

module sliding_window_maximum_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [swm_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                              in_first_of_sequence,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [swm_pkg::LEN_W-1:0]         cfg_window_len
);

  logic [swm_pkg::LEN_W-1:0] len_r;
  logic [swm_pkg::CNT_W-1:0] fill_r;
  logic [swm_pkg::CNT_W-1:0] fill_nxt;
  logic [swm_pkg::CNT_W-1:0] len_eff;
  logic [swm_pkg::IDX_W-1:0] sel_idx;
  logic                      in_acc;
  logic                      rd_blocked;
  swm_pkg::sel_ctl_t         rd_ctl;
  swm_pkg::sample_t          cell_q   [swm_pkg::WINDOW_MAX];
  swm_pkg::sample_t          cell_nxt [swm_pkg::WINDOW_MAX];

  assign cfg_ready = 1'b1;
  assign in_stall  = rd_blocked;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= swm_pkg::LEN_W'(swm_pkg::LEN_RST);
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_window_len;
    end
  end

  always_comb begin
    if (len_r == '0) begin
      len_eff = swm_pkg::CNT_W'(1);
    end else if (32'(len_r) > 32'(swm_pkg::WINDOW_MAX)) begin
      len_eff = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
    end else begin
      len_eff = swm_pkg::CNT_W'(len_r);
    end
    sel_idx = swm_pkg::IDX_W'(len_eff - swm_pkg::CNT_W'(1));
  end

  always_comb begin
    if (in_first_of_sequence) begin
      fill_nxt = swm_pkg::CNT_W'(1);
    end else if (fill_r == swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + swm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  for (genvar k = 0; k < swm_pkg::WINDOW_MAX; k++) begin : g_cell
    swm_pkg::sample_t prev;
    if (k == 0) begin : g_head
      assign prev = in_sample;
    end else begin : g_body
      assign prev = cell_q[k-1];
    end
    swm_cell u_cell (
      .clk   (clk),
      .en    (in_acc),
      .clr   (in_first_of_sequence),
      .smp   (in_sample),
      .prev  (prev),
      .m_q   (cell_q[k]),
      .m_nxt (cell_nxt[k])
    );
  end

  assign rd_ctl.vld  = in_acc && (fill_nxt >= len_eff);
  assign rd_ctl.lane = sel_idx[swm_pkg::LANE_W-1:0];
  assign rd_ctl.grp  = swm_pkg::GRP_W'(sel_idx >> swm_pkg::LANE_W);

  swm_readout u_readout (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (rd_ctl),
    .cand           (cell_nxt),
    .blocked        (rd_blocked),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max)
  );

  // A new sequence restarts the fill count at one sample.
  a_clear_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_first_of_sequence |=> fill_r == swm_pkg::CNT_W'(1))
    else $error("fill count not restarted by a new sequence");

  // The fill count saturates at the window capacity.
  a_fill_sat: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX))
    else $error("fill count above window capacity");

  // The head cell always holds the most recent sample.
  a_head_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> cell_q[0] == $past(in_sample))
    else $error("head cell does not hold the latest sample");

  // A restarted sequence gives no result unless the window is one sample long.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_first_of_sequence && (len_eff > swm_pkg::CNT_W'(1)) |-> !rd_ctl.vld)
    else $error("result issued before the window is full");

endmodule

`default_nettype wire

### hdl/swm_cell.sv
// One cell of the running maximum chain: holds the maximum of its span of samples.
// Depends on swm_pkg.
`default_nettype none

module swm_cell (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic            clr,
  input  wire swm_pkg::sample_t smp,
  input  wire swm_pkg::sample_t prev,
  output swm_pkg::sample_t      m_q,
  output swm_pkg::sample_t      m_nxt
);

  swm_pkg::sample_t m_r;

  // After a clear every cell restarts from the new sample alone.
  always_comb begin
    if (clr || (smp > prev)) begin
      m_nxt = smp;
    end else begin
      m_nxt = prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

  assign m_q = m_r;

endmodule

`default_nettype wire

### hdl/swm_readout.sv
// Two-level registered select that picks the addressed cell and holds the result.
// Depends on swm_pkg.
`default_nettype none

module swm_readout (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire swm_pkg::sel_ctl_t     ctl,
  input  wire swm_pkg::sample_t      cand [swm_pkg::WINDOW_MAX],
  output logic                       blocked,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output swm_pkg::sample_t           out_window_max
);

  swm_pkg::sample_t gp_nxt [swm_pkg::GROUPS];
  swm_pkg::sample_t gp_r   [swm_pkg::GROUPS];
  logic [swm_pkg::GRP_W-1:0] grp_r;
  logic                      s1_vld_r;
  logic                      out_vld_r;
  swm_pkg::sample_t          out_r;
  logic                      out_load;
  logic                      s1_load;

  for (genvar g = 0; g < swm_pkg::GROUPS; g++) begin : g_grp
    swm_pkg::sample_t lanes [swm_pkg::LANES];
    for (genvar l = 0; l < swm_pkg::LANES; l++) begin : g_lane
      if (g * swm_pkg::LANES + l < swm_pkg::WINDOW_MAX) begin : g_real
        assign lanes[l] = cand[g * swm_pkg::LANES + l];
      end else begin : g_pad
        assign lanes[l] = '0;
      end
    end
    assign gp_nxt[g] = lanes[ctl.lane];
  end

  assign out_load = !out_vld_r || !out_stall;
  assign s1_load  = !s1_vld_r || out_load;
  assign blocked  = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_vld_r <= ctl.vld;
      end
      if (out_load) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && ctl.vld) begin
      gp_r  <= gp_nxt;
      grp_r <= ctl.grp;
    end
    if (out_load && s1_vld_r) begin
      out_r <= gp_r[grp_r];
    end
  end

  assign out_valid      = out_vld_r;
  assign out_window_max = out_r;

endmodule

`default_nettype wire

### test/tb_sliding_window_maximum_unit.sv
// Self-checking testbench for sliding_window_maximum_unit: directed and random sample streams
// under random valid gaps and output stalls, scored against an in-bench window maximum model.
// Depends on swm_pkg and the sliding_window_maximum_unit RTL.
`timescale 1ns / 1ps

module tb_sliding_window_maximum_unit;

  typedef enum int {PAT_RANDOM, PAT_FALLING, PAT_RISING, PAT_NARROW} pattern_t;

  class window_max_scoreboard_t;
    swm_pkg::sample_t          window_mem [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::CNT_W-1:0] fill;
    logic [swm_pkg::IDX_W-1:0] wr_pos;
    logic [swm_pkg::LEN_W-1:0] win_len;
    swm_pkg::sample_t          expected_max [$];
    int                        errors;
    int                        samples_seen;
    int                        maxima_checked;

    function new();
      foreach (window_mem[i]) window_mem[i] = '0;
      fill           = '0;
      wr_pos         = '0;
      win_len        = swm_pkg::LEN_W'(swm_pkg::LEN_RST);
      errors         = 0;
      samples_seen   = 0;
      maxima_checked = 0;
    endfunction

    function void set_window_len(logic [swm_pkg::LEN_W-1:0] v);
      win_len = v;
    endfunction

    function int effective_len();
      if (win_len == 0) return 1;
      if (win_len > swm_pkg::WINDOW_MAX) return swm_pkg::WINDOW_MAX;
      return win_len;
    endfunction

    function void note_sample(swm_pkg::sample_t s, logic first);
      int                        n;
      logic [swm_pkg::IDX_W-1:0] idx;
      swm_pkg::sample_t          best;
      samples_seen++;
      if (first) begin
        fill   = '0;
        wr_pos = '0;
      end
      window_mem[wr_pos] = s;
      wr_pos = wr_pos + swm_pkg::IDX_W'(1);
      if (fill < swm_pkg::WINDOW_MAX) fill = fill + swm_pkg::CNT_W'(1);
      n = effective_len();
      if (fill < n) return;
      idx  = wr_pos - swm_pkg::IDX_W'(1);
      best = window_mem[idx];
      for (int i = 1; i < n; i++) begin
        idx = idx - swm_pkg::IDX_W'(1);
        if (window_mem[idx] > best) best = window_mem[idx];
      end
      expected_max = {expected_max, best};
    endfunction

    function void check_result(swm_pkg::sample_t got);
      swm_pkg::sample_t exp_max;
      if (expected_max.size() == 0) begin
        $error("window_max: expected no transfer, got %0d", got);
        errors++;
        return;
      end
      exp_max = expected_max.pop_front();
      maxima_checked++;
      if (got !== exp_max) begin
        $error("window_max: expected %0d, got %0d", exp_max, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_max.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  swm_pkg::sample_t          in_sample = '0;
  logic                      in_first_of_sequence = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  swm_pkg::sample_t          out_window_max;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [swm_pkg::LEN_W-1:0] cfg_window_len = '0;

  window_max_scoreboard_t sb;
  int send_idle_pct = 22;
  int recv_stall_pct = 73;
  int len_writes = 0;

  sliding_window_maximum_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .in_first_of_sequence (in_first_of_sequence),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_window_max       (out_window_max),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_window_len       (cfg_window_len)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_window_len(cfg_window_len);
      if (in_valid && !in_stall) sb.note_sample(in_sample, in_first_of_sequence);
      if (out_valid && !out_stall) sb.check_result(out_window_max);
    end
  end

  task automatic send_sample(input swm_pkg::sample_t s, input logic first);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid             <= 1'b0;
      in_sample            <= swm_pkg::sample_t'($urandom);
      in_first_of_sequence <= 1'($urandom);
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_sample            <= s;
    in_first_of_sequence <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic hold_until_drained(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [swm_pkg::LEN_W-1:0] v);
    hold_until_drained(6);
    cfg_valid      <= 1'b1;
    cfg_window_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    len_writes++;
    @(posedge clk);
  endtask

  function automatic swm_pkg::sample_t pick_sample(pattern_t pat, int k,
                                                   swm_pkg::sample_t base, int step);
    int r;
    case (pat)
      PAT_FALLING: return swm_pkg::sample_t'(base - k * step);
      PAT_RISING:  return swm_pkg::sample_t'(base + k * step);
      PAT_NARROW:  return swm_pkg::sample_t'(base + $urandom_range(7, 0));
      default: begin
        r = $urandom_range(9, 0);
        if (r == 0) return swm_pkg::sample_t'(16'h8000);
        if (r == 1) return swm_pkg::sample_t'(16'h7fff);
        return swm_pkg::sample_t'($urandom);
      end
    endcase
  endfunction

  task automatic send_sequence(input int n);
    pattern_t         pat;
    swm_pkg::sample_t base;
    int               step;
    pat  = pattern_t'($urandom_range(3, 0));
    base = swm_pkg::sample_t'($urandom);
    step = $urandom_range(300, 1);
    for (int k = 0; k < n; k++) begin
      send_sample(pick_sample(pat, k, base, step), k == 0);
    end
  endtask

  initial begin
    swm_pkg::sample_t          edge_run [7];
    logic [swm_pkg::LEN_W-1:0] len_plan [10];
    int                        budget;
    int                        sent;
    int                        n;
    int                        eff;
    bit                        paused;
    sb = new();
    edge_run = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001};
    len_plan = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd0, 7'd0, 7'd17, 7'd3};
    len_plan[6] = swm_pkg::LEN_W'($urandom_range(63, 4));
    len_plan[7] = swm_pkg::LEN_W'($urandom_range(127, 0));
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length of three, full-scale values, then a clear in the middle of a stream.
    foreach (edge_run[i]) send_sample(edge_run[i], i == 0);
    send_sample(-16'sd2, 1'b1);
    send_sample(-16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b0);
    // A zero length behaves as a window of one sample.
    write_window_len(7'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    // Growing the window mid-sequence holds off results until enough samples are in.
    write_window_len(7'd1);
    send_sample(16'sd10, 1'b1);
    send_sample(16'sd30, 1'b0);
    send_sample(16'sd20, 1'b0);
    write_window_len(7'd5);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd1, 1'b0);

    for (int k = 0; k < 10; k++) begin
      if (k == 3) begin
        send_idle_pct  = 73;
        recv_stall_pct = 22;
      end else if (k == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_window_len(len_plan[k]);
      eff    = sb.effective_len();
      budget = 25 + eff;
      sent   = 0;
      while (sent < budget) begin
        if ($urandom_range(9, 0) < 7) n = $urandom_range(eff + 40, eff);
        else n = $urandom_range(eff + 2, 1);
        send_sequence(n);
        sent += n;
        if (k == 1 && !paused) begin
          hold_until_drained(0);
          paused = 1'b1;
        end
      end
    end

    hold_until_drained(10);
    $display("Covered %0d samples and %0d window maxima across %0d length writes,",
             sb.samples_seen, sb.maxima_checked, len_writes);
    $display("including lengths 0, 1, 64, 65 and 127, stream clears and both stall mixes.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_readout.sv
hdl/sliding_window_maximum_unit.sv
test/tb_sliding_window_maximum_unit.sv
